FILE: rtl/tpp_pkg.sv
// TFTP packet parser package: limits, opcodes, parse phases, payload tags
// and the result record. Used by every module of the parser; no dependencies.
`default_nettype none

package tpp_pkg;

  localparam int NAME_MAX     = 255;
  localparam int MODE_SIZE    = 16;
  localparam int DATA_MAX     = 512;
  localparam int MESSAGE_SIZE = 256;

  localparam logic [15:0] OP_RRQ  = 16'd1;
  localparam logic [15:0] OP_WRQ  = 16'd2;
  localparam logic [15:0] OP_DATA = 16'd3;
  localparam logic [15:0] OP_ACK  = 16'd4;
  localparam logic [15:0] OP_ERR  = 16'd5;

  localparam logic [2:0] PK_NONE = 3'd0;
  localparam logic [2:0] PK_NAME = 3'd1;
  localparam logic [2:0] PK_MODE = 3'd2;
  localparam logic [2:0] PK_DATA = 3'd3;
  localparam logic [2:0] PK_MSG  = 3'd4;

  // byte count saturates here; all length checks look at values below it
  localparam logic [2:0] BCNT_MAX = 3'd7;

  typedef enum logic [2:0] {
    PH_OPC,
    PH_NAME,
    PH_MODE,
    PH_NUM,
    PH_DATA,
    PH_MSG,
    PH_SKIP
  } phase_t;

  typedef struct packed {
    logic [2:0]  payload_kind;
    logic [7:0]  payload_byte;
    logic [8:0]  payload_index;
    logic        packet_end;
    logic        packet_ok;
    logic [15:0] packet_opcode;
    logic [15:0] number_field;
    logic [7:0]  name_length;
    logic [3:0]  mode_len;
    logic [9:0]  data_len;
    logic [7:0]  msg_len;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/tpp_parse.sv
// Per-byte parse state and the combinational result of one request.
// Depends on tpp_pkg.
`default_nettype none

module tpp_parse
  import tpp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    accept,
  input  wire logic [7:0] in_byte,
  input  wire logic    last_byte,
  output result_t      res
);

  phase_t      phase, phase_next;
  logic [15:0] opcode_hold, opcode_hold_next;
  logic [2:0]  bcnt, bcnt_next;
  logic [15:0] number_hold, number_hold_next;
  logic [9:0]  field_cnt, field_cnt_next;
  logic [8:0]  name_cnt, name_cnt_next;
  logic [4:0]  mode_cnt, mode_cnt_next;
  logic [1:0]  term_seen, term_seen_next;
  logic        too_long, too_long_next;

  logic [2:0]  kind;
  logic [8:0]  idx;
  logic [9:0]  name_inc;
  logic [6:0]  mode_inc;
  logic [10:0] field_inc;
  logic [15:0] op;
  logic        op_known;
  logic        ok;
  logic        is_byte_zero;

  assign is_byte_zero = (in_byte == 8'd0);
  assign name_inc     = {1'b0, name_cnt} + 10'd1;
  assign mode_inc     = {2'b00, mode_cnt} + 7'd1;
  assign field_inc    = {1'b0, field_cnt} + 11'd1;

  always_comb begin
    phase_next       = phase;
    opcode_hold_next = opcode_hold;
    number_hold_next = number_hold;
    field_cnt_next   = field_cnt;
    name_cnt_next    = name_cnt;
    mode_cnt_next    = mode_cnt;
    term_seen_next   = term_seen;
    too_long_next    = too_long;
    kind             = PK_NONE;
    idx              = 9'd0;
    bcnt_next        = (bcnt == BCNT_MAX) ? BCNT_MAX : bcnt + 3'd1;

    unique case (phase)
      PH_OPC: begin
        opcode_hold_next = {opcode_hold[7:0], in_byte};
        if (bcnt >= 3'd1) begin
          if (opcode_hold_next == OP_RRQ || opcode_hold_next == OP_WRQ) begin
            phase_next = PH_NAME;
          end else if (opcode_hold_next == OP_DATA || opcode_hold_next == OP_ACK ||
                       opcode_hold_next == OP_ERR) begin
            phase_next = PH_NUM;
          end else begin
            phase_next = PH_SKIP;
          end
        end
      end
      PH_NAME: begin
        if (is_byte_zero) begin
          term_seen_next = 2'd1;
          phase_next     = PH_MODE;
        end else begin
          kind = PK_NAME;
          idx  = name_cnt;
          if (name_inc > 10'(NAME_MAX)) too_long_next = 1'b1;
          name_cnt_next = (name_cnt == 9'h1FF) ? name_cnt : name_inc[8:0];
        end
      end
      PH_MODE: begin
        if (is_byte_zero) begin
          term_seen_next = 2'd2;
          phase_next     = PH_SKIP;
        end else begin
          kind = PK_MODE;
          idx  = {4'd0, mode_cnt};
          if (mode_inc >= 7'(MODE_SIZE)) too_long_next = 1'b1;
          mode_cnt_next = (mode_cnt == 5'h1F) ? mode_cnt : mode_inc[4:0];
        end
      end
      PH_NUM: begin
        number_hold_next = {number_hold[7:0], in_byte};
        if (bcnt >= 3'd3) begin
          if (opcode_hold == OP_DATA) begin
            phase_next = PH_DATA;
          end else if (opcode_hold == OP_ERR) begin
            phase_next = PH_MSG;
          end else begin
            phase_next = PH_SKIP;
          end
        end
      end
      PH_DATA: begin
        kind = PK_DATA;
        idx  = field_cnt[9] ? 9'h1FF : field_cnt[8:0];
        if (field_inc > 11'(DATA_MAX)) too_long_next = 1'b1;
        field_cnt_next = (field_cnt == 10'h3FF) ? field_cnt : field_inc[9:0];
      end
      PH_MSG: begin
        if (is_byte_zero) begin
          term_seen_next = 2'd1;
          phase_next     = PH_SKIP;
        end else begin
          kind = PK_MSG;
          idx  = field_cnt[9] ? 9'h1FF : field_cnt[8:0];
          if (field_inc >= 11'(MESSAGE_SIZE)) too_long_next = 1'b1;
          field_cnt_next = (field_cnt == 10'h3FF) ? field_cnt : field_inc[9:0];
        end
      end
      PH_SKIP: begin
      end
      default: begin
      end
    endcase
  end

  // verdict from the updated state
  assign op       = (bcnt_next >= 3'd2) ? opcode_hold_next : 16'd0;
  assign op_known = (op == OP_DATA || op == OP_ACK || op == OP_ERR);

  always_comb begin
    ok = 1'b0;
    if (op == OP_RRQ || op == OP_WRQ) begin
      ok = (bcnt_next >= 3'd6) && (term_seen_next == 2'd2) && !too_long_next;
    end else if (op == OP_DATA) begin
      ok = (bcnt_next >= 3'd4) && !too_long_next;
    end else if (op == OP_ACK) begin
      ok = (bcnt_next == 3'd4);
    end else if (op == OP_ERR) begin
      ok = (bcnt_next >= 3'd5) && (term_seen_next >= 2'd1) && !too_long_next;
    end
  end

  always_comb begin
    res                = '0;
    res.payload_kind   = kind;
    res.payload_byte   = (kind != PK_NONE) ? in_byte : 8'd0;
    res.payload_index  = idx;
    if (last_byte) begin
      res.packet_end     = 1'b1;
      res.packet_ok      = ok;
      res.packet_opcode  = op;
      res.number_field   = (bcnt_next >= 3'd4 && op_known) ? number_hold_next : 16'd0;
      res.name_length    = name_cnt_next[8] ? 8'hFF : name_cnt_next[7:0];
      res.mode_len       = mode_cnt_next[4] ? 4'hF : mode_cnt_next[3:0];
      res.data_len       = (op == OP_DATA) ? field_cnt_next : 10'd0;
      res.msg_len        = (op != OP_ERR) ? 8'd0 :
                           ((field_cnt_next[9:8] != 2'd0) ? 8'hFF : field_cnt_next[7:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && last_byte)) begin
      phase       <= PH_OPC;
      opcode_hold <= '0;
      bcnt        <= '0;
      number_hold <= '0;
      field_cnt   <= '0;
      name_cnt    <= '0;
      mode_cnt    <= '0;
      term_seen   <= '0;
      too_long    <= 1'b0;
    end else if (accept) begin
      phase       <= phase_next;
      opcode_hold <= opcode_hold_next;
      bcnt        <= bcnt_next;
      number_hold <= number_hold_next;
      field_cnt   <= field_cnt_next;
      name_cnt    <= name_cnt_next;
      mode_cnt    <= mode_cnt_next;
      term_seen   <= term_seen_next;
      too_long    <= too_long_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tpp_out_buf.sv
// Two-entry result buffer: output register plus skid entry, so a new
// request is taken while a result waits. Depends on tpp_pkg.
`default_nettype none

module tpp_out_buf
  import tpp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire result_t push_data,
  output logic         can_push,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_data
);

  logic    skid_valid;
  result_t skid_data;
  logic    main_free;

  assign can_push  = !skid_valid;
  assign main_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (main_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (main_free) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tftp_packet_parser.sv
// TFTP packet parser top level: byte parser feeding a two-entry result buffer.
// Depends on tpp_pkg, tpp_parse and tpp_out_buf.
//
//   channel | handshake            | payload
//   --------+----------------------+---------------------------------------
//   in      | in_valid / in_ready  | in_byte, last_byte
//   out     | out_valid/ out_ready | payload_*, packet_*, number_field, name_length, *_len
//
// One request per cycle while in_ready is high; each result is registered in the output
// register, or first in the skid entry while the output stalls; the parse stage is combinational.
// in_ready drops only when both buffer entries hold results.
// Synchronous reset returns the parser to the start of a packet and empties
// the buffer; a last_byte request does the same for the parse state.
`default_nettype none

module tftp_packet_parser
  import tpp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  input  wire logic        last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       payload_kind,
  output logic [7:0]       payload_byte,
  output logic [8:0]       payload_index,
  output logic             packet_end,
  output logic             packet_ok,
  output logic [15:0]      packet_opcode,
  output logic [15:0]      number_field,
  output logic [7:0]       name_length,
  output logic [3:0]       mode_len,
  output logic [9:0]       data_len,
  output logic [7:0]       msg_len
);

  logic    accept;
  result_t res;
  result_t out_data;

  assign accept = in_valid && in_ready;

  tpp_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_byte   (in_byte),
    .last_byte (last_byte),
    .res       (res)
  );

  tpp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (res),
    .can_push  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign payload_kind   = out_data.payload_kind;
  assign payload_byte   = out_data.payload_byte;
  assign payload_index  = out_data.payload_index;
  assign packet_end     = out_data.packet_end;
  assign packet_ok      = out_data.packet_ok;
  assign packet_opcode  = out_data.packet_opcode;
  assign number_field   = out_data.number_field;
  assign name_length    = out_data.name_length;
  assign mode_len       = out_data.mode_len;
  assign data_len       = out_data.data_len;
  assign msg_len        = out_data.msg_len;

endmodule

`default_nettype wire

FILE: rtl/tpp_checker.sv
// Port-level checks for tftp_packet_parser, bound to the top level.
// Depends on tpp_pkg.
`default_nettype none

module tpp_checker
  import tpp_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  payload_kind,
  input wire logic [7:0]  payload_byte,
  input wire logic [8:0]  payload_index,
  input wire logic        packet_end,
  input wire logic        packet_ok,
  input wire logic [15:0] packet_opcode,
  input wire logic [9:0]  data_len
);

  // a stalled result stays up
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // back-pressure only with a result pending
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("in_ready low with empty output");

  a_untagged_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && payload_kind == PK_NONE |-> payload_byte == 8'd0 && payload_index == 9'd0)
    else $error("untagged result carries content");

  a_mid_packet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !packet_end |-> !packet_ok && packet_opcode == 16'd0)
    else $error("verdict fields set before packet end");

  a_data_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && packet_end && packet_opcode != OP_DATA |-> data_len == 10'd0)
    else $error("data length on non-DATA packet");

endmodule

bind tftp_packet_parser tpp_checker u_tpp_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .payload_kind  (payload_kind),
  .payload_byte  (payload_byte),
  .payload_index (payload_index),
  .packet_end    (packet_end),
  .packet_ok     (packet_ok),
  .packet_opcode (packet_opcode),
  .data_len      (data_len)
);

`default_nettype wire

FILE: tb/tb_tftp_packet_parser.sv
// Testbench for tftp_packet_parser: byte requests from a queue, with random gaps and stalls,
// checked against an in-bench TFTP parse predictor. Depends on tpp_pkg and the parser RTL.
`timescale 1ns / 100ps

module tb_tftp_packet_parser
  import tpp_pkg::*;
();

  localparam int CYCLE_LIMIT = 400000;
  localparam int TOTAL_BYTES = 850;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } byte_req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'd0;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  payload_kind;
  logic [7:0]  payload_byte;
  logic [8:0]  payload_index;
  logic        packet_end;
  logic        packet_ok;
  logic [15:0] packet_opcode;
  logic [15:0] number_field;
  logic [7:0]  name_length;
  logic [3:0]  mode_len;
  logic [9:0]  data_len;
  logic [7:0]  msg_len;

  byte_req_t   packet_bytes[$];
  logic [7:0]  pkt[$];
  result_t     predicted_results[$];
  int          mismatches = 0;
  int          cycle_count = 0;
  int          sent_count = 0;
  logic        in_took = 1'b0;
  logic        calm;

  // parse state copy
  phase_t      st_phase;
  logic [15:0] st_opcode;
  int          st_bytes;
  logic [15:0] st_number;
  int          st_field;
  int          st_name;
  int          st_mode;
  logic [1:0]  st_terms;
  logic        st_too_long;

  tftp_packet_parser DUT (
    .clk, .rst, .in_valid, .in_ready, .in_byte, .last_byte, .out_valid, .out_ready,
    .payload_kind, .payload_byte, .payload_index, .packet_end, .packet_ok, .packet_opcode,
    .number_field, .name_length, .mode_len, .data_len, .msg_len
  );

  always #6 clk = ~clk;

  assign calm = (sent_count >= 200) && (sent_count < 420);

  function automatic int cap(input int v, input int lim);
    return (v > lim) ? lim : v;
  endfunction

  function automatic void clear_parse_state();
    st_phase    = PH_OPC;
    st_opcode   = '0;
    st_bytes    = 0;
    st_number   = '0;
    st_field    = 0;
    st_name     = 0;
    st_mode     = 0;
    st_terms    = '0;
    st_too_long = 1'b0;
  endfunction

  function automatic result_t parse_tftp_byte(input logic [7:0] b, input logic fin);
    result_t     r;
    int          pos;
    logic [15:0] op;
    logic        ok;
    r = '0;
    pos = st_bytes;
    st_bytes = cap(pos + 1, 65535);
    case (st_phase)
      PH_OPC: begin
        st_opcode = {st_opcode[7:0], b};
        if (pos >= 1) begin
          if (st_opcode == OP_RRQ || st_opcode == OP_WRQ) st_phase = PH_NAME;
          else if (st_opcode >= OP_DATA && st_opcode <= OP_ERR) st_phase = PH_NUM;
          else st_phase = PH_SKIP;
        end
      end
      PH_NAME: begin
        if (b == 8'd0) begin
          st_terms = 2'd1;
          st_phase = PH_MODE;
        end else begin
          r.payload_kind = PK_NAME;
          r.payload_index = st_name[8:0];
          if (st_name + 1 > NAME_MAX) st_too_long = 1'b1;
          st_name = cap(st_name + 1, 511);
        end
      end
      PH_MODE: begin
        if (b == 8'd0) begin
          st_terms = 2'd2;
          st_phase = PH_SKIP;
        end else begin
          r.payload_kind = PK_MODE;
          r.payload_index = st_mode[8:0];
          if (st_mode + 1 >= MODE_SIZE) st_too_long = 1'b1;
          st_mode = cap(st_mode + 1, 31);
        end
      end
      PH_NUM: begin
        st_number = {st_number[7:0], b};
        if (pos >= 3) begin
          if (st_opcode == OP_DATA) st_phase = PH_DATA;
          else if (st_opcode == OP_ERR) st_phase = PH_MSG;
          else st_phase = PH_SKIP;
        end
      end
      PH_DATA: begin
        r.payload_kind = PK_DATA;
        r.payload_index = 9'(cap(st_field, 511));
        if (st_field + 1 > DATA_MAX) st_too_long = 1'b1;
        st_field = cap(st_field + 1, 1023);
      end
      PH_MSG: begin
        if (b == 8'd0) begin
          st_terms = 2'd1;
          st_phase = PH_SKIP;
        end else begin
          r.payload_kind = PK_MSG;
          r.payload_index = 9'(cap(st_field, 511));
          if (st_field + 1 >= MESSAGE_SIZE) st_too_long = 1'b1;
          st_field = cap(st_field + 1, 1023);
        end
      end
      default: ;
    endcase
    if (r.payload_kind != PK_NONE) r.payload_byte = b;

    if (fin) begin
      op = (st_bytes >= 2) ? st_opcode : 16'd0;
      ok = 1'b0;
      if (st_bytes >= 2) begin
        case (op)
          OP_RRQ, OP_WRQ: ok = (st_bytes >= 6) && (st_terms == 2'd2) && !st_too_long;
          OP_DATA:        ok = (st_bytes >= 4) && !st_too_long;
          OP_ACK:         ok = (st_bytes == 4);
          OP_ERR:         ok = (st_bytes >= 5) && (st_terms >= 2'd1) && !st_too_long;
          default:        ok = 1'b0;
        endcase
      end
      r.packet_end     = 1'b1;
      r.packet_ok      = ok;
      r.packet_opcode  = op;
      r.number_field   = (st_bytes >= 4 && op >= OP_DATA && op <= OP_ERR) ? st_number : 16'd0;
      r.name_length    = 8'(cap(st_name, 255));
      r.mode_len       = 4'(cap(st_mode, 15));
      r.data_len       = (op == OP_DATA) ? 10'(st_field) : 10'd0;
      r.msg_len        = (op == OP_ERR) ? 8'(cap(st_field, 255)) : 8'd0;
      clear_parse_state();
    end
    return r;
  endfunction

  task automatic note_mismatch(input string what, input logic [15:0] want,
                               input logic [15:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %0h, got %0h", what, want, got);
  endtask

  task automatic compare_result(input result_t want, input result_t got);
    if (got.payload_kind !== want.payload_kind)
      note_mismatch("payload_kind", want.payload_kind, got.payload_kind);
    if (got.payload_byte !== want.payload_byte)
      note_mismatch("payload_byte", want.payload_byte, got.payload_byte);
    if (got.payload_index !== want.payload_index)
      note_mismatch("payload_index", want.payload_index, got.payload_index);
    if (got.packet_end !== want.packet_end)
      note_mismatch("packet_end", want.packet_end, got.packet_end);
    if (got.packet_ok !== want.packet_ok)
      note_mismatch("packet_ok", want.packet_ok, got.packet_ok);
    if (got.packet_opcode !== want.packet_opcode)
      note_mismatch("packet_opcode", want.packet_opcode, got.packet_opcode);
    if (got.number_field !== want.number_field)
      note_mismatch("number_field", want.number_field, got.number_field);
    if (got.name_length !== want.name_length)
      note_mismatch("name_length", want.name_length, got.name_length);
    if (got.mode_len !== want.mode_len)
      note_mismatch("mode_len", want.mode_len, got.mode_len);
    if (got.data_len !== want.data_len)
      note_mismatch("data_len", want.data_len, got.data_len);
    if (got.msg_len !== want.msg_len)
      note_mismatch("msg_len", want.msg_len, got.msg_len);
  endtask

  function automatic void put(input logic [7:0] b);
    pkt.push_back(b);
  endfunction

  function automatic void put_opcode(input logic [15:0] op);
    pkt.push_back(op[15:8]);
    pkt.push_back(op[7:0]);
  endfunction

  function automatic void put_text(input int len, input logic nonzero);
    for (int i = 0; i < len; i++)
      pkt.push_back(nonzero ? 8'($urandom_range(1, 255)) : 8'($urandom_range(0, 255)));
  endfunction

  // keep = bytes actually sent; 0 sends the whole packet
  function automatic void commit_packet(input int keep);
    int n;
    n = (keep < 1 || keep > pkt.size()) ? pkt.size() : keep;
    for (int i = 0; i < n; i++)
      packet_bytes.push_back('{data: pkt[i], fin: (i == n - 1)});
    pkt.delete();
  endfunction

  // request driver
  always @(negedge clk) begin : drive_requests
    byte_req_t req;
    if (!rst) begin
      if (!in_valid || in_took) begin
        if (packet_bytes.size() > 0 && (calm || $urandom_range(0, 99) >= 38)) begin
          req = packet_bytes.pop_front();
          in_valid  <= 1'b1;
          in_byte   <= req.data;
          last_byte <= req.fin;
          sent_count <= sent_count + 1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= calm || ($urandom_range(0, 99) >= 38);
    end
  end

  // monitor and checker
  always @(posedge clk) begin : watch_results
    result_t got;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_tftp_packet_parser failed");
      $finish;
    end
    if (rst) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        got = {payload_kind, payload_byte, payload_index, packet_end, packet_ok,
               packet_opcode, number_field, name_length, mode_len, data_len,
               msg_len};
        if (predicted_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: result with no request pending");
        end else begin
          compare_result(predicted_results.pop_front(), got);
        end
      end
      if (in_valid && in_ready) predicted_results.push_back(parse_tftp_byte(in_byte, last_byte));
    end
  end

  initial begin
    int sel;
    int len;
    clear_parse_state();

    // directed: one-byte packet, unknown opcode, exact ACK, minimal RRQ, empty DATA, ERROR
    put(8'h00); commit_packet(0);
    put_opcode(16'h0007); put(8'hAA); commit_packet(0);
    put_opcode(OP_ACK); put(8'hFF); put(8'hFF); commit_packet(0);
    put_opcode(OP_RRQ); put(8'h61); put(8'h00); put(8'h62); put(8'h00); commit_packet(0);
    put_opcode(OP_DATA); put(8'h00); put(8'h01); commit_packet(0);
    put_opcode(OP_ERR); put(8'h00); put(8'h02); put(8'h00); commit_packet(0);

    // overlong fields
    put_opcode(OP_DATA); put(8'h12); put(8'h34); put_text(DATA_MAX + 1, 1'b0); commit_packet(0);
    put_opcode(OP_WRQ); put_text(NAME_MAX + 1, 1'b1); put(8'h00); put_text(5, 1'b1);
    put(8'h00); commit_packet(0);

    while (packet_bytes.size() < TOTAL_BYTES) begin
      sel = $urandom_range(0, 99);
      if (sel < 25) begin
        put_opcode(($urandom_range(0, 1) != 0) ? OP_RRQ : OP_WRQ);
        put_text($urandom_range(0, 16), 1'b1);
        put(8'h00);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(MODE_SIZE - 1, MODE_SIZE)
                                          : $urandom_range(1, 8);
        put_text(len, 1'b1);
        put(8'h00);
        if ($urandom_range(0, 4) == 0) put_text($urandom_range(1, 3), 1'b0);
      end else if (sel < 45) begin
        put_opcode(OP_DATA);
        put_text(2 + $urandom_range(0, 24), 1'b0);
      end else if (sel < 60) begin
        put_opcode(OP_ACK);
        put_text(2, 1'b0);
        if ($urandom_range(0, 3) == 0) put_text($urandom_range(1, 3), 1'b0);
      end else if (sel < 80) begin
        put_opcode(OP_ERR);
        put_text(2, 1'b0);
        put_text($urandom_range(0, 20), 1'b1);
        put(8'h00);
        if ($urandom_range(0, 4) == 0) put_text($urandom_range(1, 3), 1'b0);
      end else begin
        // unknown or random opcodes
        put(($urandom_range(0, 1) != 0) ? 8'h00 : 8'($urandom_range(0, 255)));
        put(8'($urandom_range(0, 15)));
        put_text($urandom_range(0, 6), 1'b0);
      end
      commit_packet(($urandom_range(0, 7) == 0) ? $urandom_range(1, pkt.size()) : 0);
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (packet_bytes.size() > 0 || in_valid || predicted_results.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && predicted_results.size() == 0)
      $display("tb_tftp_packet_parser passed");
    else
      $display("tb_tftp_packet_parser failed");
    $finish;
  end

endmodule

FILE: files.f
rtl/tpp_pkg.sv
rtl/tpp_parse.sv
rtl/tpp_out_buf.sv
rtl/tftp_packet_parser.sv
rtl/tpp_checker.sv
tb/tb_tftp_packet_parser.sv
